>>> hdl/radix_digit_converter_assert.svh
// assertion macros used by the port-level checker of the radix digit converter
`ifndef RADIX_DIGIT_CONVERTER_ASSERT_SVH
`define RADIX_DIGIT_CONVERTER_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off while i_rst_n is low
`define RDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/rdc_pkg.sv
// shared constants, types and control structs of the radix digit converter
package rdc_pkg;

    localparam int VALUE_WIDTH = 31;
    localparam int BASE_W      = 4;
    localparam int DIGIT_W     = 4;
    localparam logic [BASE_W-1:0] MIN_BASE = 4'd2;
    localparam logic [BASE_W-1:0] MAX_BASE = 4'd10;

    // dividend bits retired per division cycle
    localparam int STEP_BITS = 8;
    localparam int N_CHUNK   = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
    localparam int DIV_W     = N_CHUNK * STEP_BITS;
    localparam int CHUNK_W   = (N_CHUNK > 1) ? $clog2(N_CHUNK) : 1;

    // digit stack
    localparam int PTR_W = $clog2(VALUE_WIDTH);
    localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

    localparam int IN_DATA_W  = ((VALUE_WIDTH + BASE_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((DIGIT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_RD,
        S_LD,
        S_ERR
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic rd;
        logic push_digit;
        logic push_err;
    } t_cmd;

    typedef struct packed {
        logic base_ok;
        logic digit_done;
        logic quot_zero;
        logic cnt_one;
        logic out_free;
    } t_status;

endpackage

>>> hdl/rdc_ram.sv
// generic single-port-write, single-port-read ram with registered read
module rdc_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 31
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/rdc_ctrl.sv
// sequencing state machine of the radix digit converter
module rdc_ctrl import rdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_s_axis_tvalid,
    output logic    o_s_axis_tready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   s_fire;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign s_fire          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_fire) begin
                    n_state = i_status.base_ok ? S_DIV : S_ERR;
                end
            end
            S_DIV: begin
                if (i_status.digit_done && i_status.quot_zero) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (i_status.out_free) begin
                    n_state = i_status.cnt_one ? S_IDLE : S_RD;
                end
            end
            S_ERR: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            S_IDLE: o_cmd.load       = s_fire;
            S_DIV:  o_cmd.step       = 1'b1;
            S_RD:   o_cmd.rd         = 1'b1;
            S_LD:   o_cmd.push_digit = i_status.out_free;
            S_ERR:  o_cmd.push_err   = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule

>>> hdl/rdc_datapath.sv
// divider, digit stack and output register of the radix digit converter
module rdc_datapath import rdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input  t_cmd                  i_cmd,
    output t_status               o_status,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    output logic                  o_m_axis_tlast,
    output logic                  o_m_axis_tuser
);

    logic [VALUE_WIDTH-1:0] in_value;
    logic [BASE_W-1:0]      in_base;

    logic [DIV_W-1:0]       r_q;
    logic [DIGIT_W-1:0]     r_rem;
    logic [BASE_W-1:0]      r_base;
    logic [CHUNK_W-1:0]     r_chunk;
    logic [CNT_W-1:0]       r_cnt;

    logic [DIGIT_W-1:0]     rem_w;
    logic [DIGIT_W:0]       trial;
    logic [STEP_BITS-1:0]   qbits;
    logic [DIV_W+STEP_BITS-1:0] shifted;
    logic [DIV_W-1:0]       q_next;
    logic                   chunk_last;
    logic [CNT_W-1:0]       cnt_dec;

    logic [DIGIT_W-1:0]     ram_rd_data;

    logic                   r_out_valid;
    logic [DIGIT_W-1:0]     r_digit;
    logic                   r_last;
    logic                   r_err;

    assign in_value = i_s_axis_tdata[VALUE_WIDTH-1:0];
    assign in_base  = i_s_axis_tdata[VALUE_WIDTH+BASE_W-1:VALUE_WIDTH];

    // restoring division, STEP_BITS dividend bits per cycle, msb first
    always_comb begin
        rem_w = r_rem;
        trial = '0;
        qbits = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            trial = {rem_w, r_q[DIV_W-1-i]};
            if (trial >= {1'b0, r_base}) begin
                trial = trial - {1'b0, r_base};
                qbits[STEP_BITS-1-i] = 1'b1;
            end
            rem_w = trial[DIGIT_W-1:0];
        end
    end

    assign shifted    = {r_q, qbits};
    assign q_next     = shifted[DIV_W-1:0];
    assign chunk_last = (r_chunk == CHUNK_W'(N_CHUNK - 1));
    assign cnt_dec    = r_cnt - CNT_W'(1);

    assign o_status.base_ok    = (in_base >= MIN_BASE) && (in_base <= MAX_BASE);
    assign o_status.digit_done = i_cmd.step && chunk_last;
    assign o_status.quot_zero  = (q_next == '0);
    assign o_status.cnt_one    = (r_cnt == CNT_W'(1));
    assign o_status.out_free   = !r_out_valid || i_m_axis_tready;

    rdc_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (VALUE_WIDTH)
    ) u_stack (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.step && chunk_last),
        .i_wr_addr (r_cnt[PTR_W-1:0]),
        .i_wr_data (rem_w),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (cnt_dec[PTR_W-1:0]),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_chunk <= '0;
                r_cnt   <= '0;
            end else if (i_cmd.step) begin
                if (chunk_last) begin
                    r_chunk <= '0;
                    r_cnt   <= r_cnt + CNT_W'(1);
                end else begin
                    r_chunk <= r_chunk + CHUNK_W'(1);
                end
            end else if (i_cmd.push_digit) begin
                r_cnt <= cnt_dec;
            end

            if (i_cmd.push_digit || i_cmd.push_err) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_q    <= DIV_W'(in_value);
            r_rem  <= '0;
            r_base <= in_base;
        end else if (i_cmd.step) begin
            r_q   <= q_next;
            // each digit starts its division with a clear remainder
            r_rem <= chunk_last ? '0 : rem_w;
        end

        if (i_cmd.push_digit) begin
            r_digit <= ram_rd_data;
            r_last  <= (r_cnt == CNT_W'(1));
            r_err   <= 1'b0;
        end else if (i_cmd.push_err) begin
            r_digit <= '0;
            r_last  <= 1'b1;
            r_err   <= 1'b1;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W-DIGIT_W){1'b0}}, r_digit};
    assign o_m_axis_tlast  = r_last;
    assign o_m_axis_tuser  = r_err;

endmodule

>>> hdl/radix_digit_converter.sv
// top level of the radix digit converter
//
// input stream: one transfer carries a value and a target base. a base of
// 2 to 10 yields the digits of the value in that base, most significant
// first, with tlast on the final digit; zero yields the single digit 0.
// any other base yields one transfer with digit 0, tlast and tuser set.
// one item is converted at a time; s_axis_tready is high only while the
// block waits for a new item.
// steps per item: an accept, then per digit a division over N_CHUNK (4 at 31
// bits) chunks by the 8-bit-per-cycle restoring divider, then per digit a
// read state and a load state to pop the digit stack through its registered
// read port.
// the last digit sits in the output register, so the next item is
// accepted and divided while that digit waits to be taken.
// a stalled receiver holds the output register and pauses the stack pop.
// reset (synchronous, active low) returns to idle and drops m_axis_tvalid;
// the digit stack needs no clearing.
module radix_digit_converter import rdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // value, base
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,   // digit
    output logic                  o_m_axis_tlast,
    output logic                  o_m_axis_tuser    // error
);

    t_cmd    cmd;
    t_status status;

    rdc_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    rdc_datapath u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_cmd           (cmd),
        .o_status        (status),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

endmodule

>>> hdl/rdc_checker.sv
// port-level assertions of the radix digit converter and their bind
`include "radix_digit_converter_assert.svh"

module rdc_checker import rdc_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic                  o_m_axis_tlast,
    input logic                  o_m_axis_tuser
);

    `RDC_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast) && $stable(o_m_axis_tuser), "stalled output transfer changed")
    `RDC_ASSERT_IMP(a_err_shape, o_m_axis_tvalid && o_m_axis_tuser, o_m_axis_tlast && (o_m_axis_tdata == '0), "error result not a single zero digit")
    `RDC_ASSERT_IMP(a_digit_range, o_m_axis_tvalid, o_m_axis_tdata <= OUT_DATA_W'(MAX_BASE - 4'd1), "digit out of decimal range")
    `RDC_ASSERT_NXT(a_busy_after_accept, i_s_axis_tvalid && o_s_axis_tready, !o_s_axis_tready, "input accepted while converting")

endmodule

bind radix_digit_converter rdc_checker u_rdc_checker (.*);

>>> sim/rdc_checker.sv
// checker for the radix digit converter: predicts the digit stream and compares it
module rdc_scoreboard import rdc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  i_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,   // value, base
    input  logic                  i_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [OUT_DATA_W-1:0] i_m_axis_tdata,   // digit
    input  logic                  i_m_axis_tlast,
    input  logic                  i_m_axis_tuser,   // error
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               bad_base;
    } t_digit_out;

    t_digit_out digit_q[$];
    int         fail_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = digit_q.size();

    // expands one conversion into its digit transfers, most significant first
    function automatic void push_digits_of(input logic [VALUE_WIDTH-1:0] value,
                                           input logic [BASE_W-1:0] base);
        logic [DIGIT_W-1:0]     rem_q[$];
        logic [VALUE_WIDTH-1:0] rest;
        t_digit_out             item;
        if (base < MIN_BASE || base > MAX_BASE) begin
            item = '{digit: '0, last: 1'b1, bad_base: 1'b1};
            digit_q.push_back(item);
            return;
        end
        rest = value;
        do begin
            rem_q.push_front(DIGIT_W'(rest % VALUE_WIDTH'(base)));
            rest = rest / VALUE_WIDTH'(base);
        end while (rest != 0);
        foreach (rem_q[k]) begin
            item = '{digit: rem_q[k], last: (k == rem_q.size() - 1), bad_base: 1'b0};
            digit_q.push_back(item);
        end
    endfunction

    function automatic void note_mismatch(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("rdc_checker: mismatch at %0t: %s", $realtime, what);
    endfunction

    always @(posedge i_clk) begin
        t_digit_out want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && i_s_axis_tready)
                push_digits_of(i_s_axis_tdata[VALUE_WIDTH-1:0],
                               i_s_axis_tdata[VALUE_WIDTH +: BASE_W]);
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (digit_q.size() == 0) begin
                    note_mismatch($sformatf(
                        "unexpected transfer digit=%0d last=%0b err=%0b",
                        i_m_axis_tdata[DIGIT_W-1:0], i_m_axis_tlast,
                        i_m_axis_tuser));
                end else begin
                    want = digit_q.pop_front();
                    if (i_m_axis_tdata[DIGIT_W-1:0] !== want.digit ||
                        i_m_axis_tlast !== want.last || i_m_axis_tuser !== want.bad_base)
                        note_mismatch($sformatf(
                            {"expected digit=%0d last=%0b err=%0b, ",
                             "got digit=%0d last=%0b err=%0b"},
                            want.digit, want.last, want.bad_base,
                            i_m_axis_tdata[DIGIT_W-1:0], i_m_axis_tlast, i_m_axis_tuser));
                end
            end
        end
    end

endmodule

>>> sim/tb.sv
// testbench top for the radix digit converter: stimulus, clock, reset and verdict
module tb;
    import rdc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM    = 460;
    localparam int QUIET_TAIL  = 60;
    localparam int DRAIN_WAIT  = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;
    logic                  m_tuser;
    int                    fail_count;
    int                    pending;

    // 0: no idling, 1..2: growing chance of idle bursts on both sides
    int idle_level = 0;
    int stall_left = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    radix_digit_converter dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tlast  (m_tlast),
        .o_m_axis_tuser  (m_tuser)
    );

    rdc_scoreboard checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tlast  (m_tlast),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // receiver back-pressure in bursts, only while idle_level is above zero
    always @(posedge i_clk) begin
        if (idle_level == 0) begin
            m_tready   <= 1'b1;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 7) < idle_level) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(1, 5) - 1;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic put_item(input logic [VALUE_WIDTH-1:0] value,
                            input logic [BASE_W-1:0] base);
        int gap;
        if (idle_level > 0 && $urandom_range(0, 3) < idle_level) begin
            gap = $urandom_range(1, 5);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W - VALUE_WIDTH - BASE_W){1'b0}}, base, value};
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic logic [BASE_W-1:0] pick_base();
        int r;
        if ($urandom_range(0, 9) == 0) begin
            // out-of-range radix: 0, 1 or 11..15
            r = $urandom_range(0, 6);
            return BASE_W'((r < 2) ? r : r + 9);
        end
        return BASE_W'($urandom_range(MIN_BASE, MAX_BASE));
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] pick_value(input logic [BASE_W-1:0] base);
        logic [63:0] p;
        int          steps;
        case ($urandom_range(0, 3))
            0: return VALUE_WIDTH'($urandom);
            1: return VALUE_WIDTH'($urandom_range(0, 120));
            2: begin
                // around a power of the base, where the digit count changes
                p = 64'd1;
                steps = $urandom_range(0, 31);
                if (base >= MIN_BASE)
                    repeat (steps)
                        if (p * base < (64'd1 << VALUE_WIDTH)) p = p * base;
                return VALUE_WIDTH'(p - $urandom_range(0, 1));
            end
            default: return ~VALUE_WIDTH'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        logic [VALUE_WIDTH-1:0] all_ones;
        logic [BASE_W-1:0]      b;
        all_ones = '1;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero in every radix, valid and invalid
        for (int r = 0; r < 16; r++)
            put_item('0, BASE_W'(r));
        put_item(all_ones, 4'd2);
        put_item(all_ones, MAX_BASE);
        put_item(all_ones, 4'd3);
        put_item(VALUE_WIDTH'(1), MIN_BASE);
        put_item(VALUE_WIDTH'(9), MAX_BASE);
        put_item(VALUE_WIDTH'(10), MAX_BASE);
        put_item(all_ones, 4'd0);
        put_item(all_ones, 4'd15);
        put_item(all_ones, 4'd11);

        for (int i = 0; i < N_RANDOM; i++) begin
            if (i >= N_RANDOM - QUIET_TAIL)
                idle_level = 0;
            else if (i % 40 == 0)
                idle_level = $urandom_range(0, 2);
            b = pick_base();
            put_item(pick_value(b), b);
        end
        s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    initial begin
        #4000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

>>> radix_digit_converter.f
+incdir+hdl
hdl/rdc_pkg.sv
hdl/rdc_ram.sv
hdl/rdc_ctrl.sv
hdl/rdc_datapath.sv
hdl/radix_digit_converter.sv
hdl/rdc_checker.sv
sim/rdc_checker.sv
sim/tb.sv
